// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/rsst_pkg.sv =====
// Types and constants of the range-sum segment tree
package rsst_pkg;

    localparam int unsigned LEAVES = 1024;
    localparam int unsigned NODES  = 2 * LEAVES;
    localparam int unsigned NODE_W = $clog2(NODES);
    // node pair bounds of a query reach NODES itself
    localparam int unsigned AB_W   = NODE_W + 1;
    localparam int unsigned POS_W  = 10;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned SUM_W  = 42;

    typedef struct packed {
        logic                    mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] new_value;
        logic [POS_W-1:0]        range_low;
        logic [POS_W-1:0]        range_high;
    } t_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_total;
        logic                    status;
    } t_result;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_REPLY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic                    status;
        logic [POS_W-1:0]        leaf;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        lo;
        logic [POS_W-1:0]        hi;
    } t_cmd;

endpackage

// ===== hw/rtl/rsst_front.sv =====
// Front end: accepts items, classifies them and queues commands for the tree engine
module rsst_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsst_pkg::t_item i_item,
    input  logic           i_push,
    input  logic           i_hold,
    output logic           o_full,
    output rsst_pkg::t_cmd o_cmd,
    output logic           o_cmd_empty,
    input  logic           i_cmd_pop
);
    import rsst_pkg::*;

    t_cmd             w_cmd;
    logic [POS_W-1:0] w_hi_c;
    logic             w_accept;
    logic             w_pop;
    t_cmd             r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    // clamp the range end to the last leaf
    always_comb begin
        if (32'(i_item.range_high) >= LEAVES) begin
            w_hi_c = POS_W'(LEAVES - 1);
        end else begin
            w_hi_c = i_item.range_high;
        end
    end

    always_comb begin
        w_cmd.kind   = CMD_REPLY;
        w_cmd.status = 1'b0;
        w_cmd.leaf   = i_item.position;
        w_cmd.value  = i_item.new_value;
        w_cmd.lo     = i_item.range_low;
        w_cmd.hi     = w_hi_c;
        if (!i_item.mode) begin
            // drop writes beyond the leaves, still answer them
            if (32'(i_item.position) < LEAVES) begin
                w_cmd.kind = CMD_WRITE;
            end
        end else if (i_item.range_low > i_item.range_high) begin
            w_cmd.status = 1'b1;
        end else if (i_item.range_low <= w_hi_c) begin
            w_cmd.kind = CMD_QUERY;
        end
    end

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign o_cmd_empty = (r_cnt == 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_accept    = i_push && !o_full;
    assign w_pop       = i_cmd_pop && !o_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_accept) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_accept) - 2'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/rsst_back.sv =====
// Tree engine: holds the sum tree, runs leaf updates and range queries
module rsst_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsst_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output rsst_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full,
    output logic              o_clearing
);
    import rsst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WSUM,
        S_QA,
        S_QB,
        S_REPLY
    } t_state;

    logic signed [SUM_W-1:0] r_mem [NODES];
    logic signed [SUM_W-1:0] r_rdata;

    t_state                  r_state, n_state;
    logic [NODE_W-1:0]       r_clr_idx, n_clr_idx;
    logic [NODE_W-1:0]       r_node, n_node;
    logic signed [SUM_W-1:0] r_cur, n_cur;
    logic [AB_W-1:0]         r_a, n_a;
    logic [AB_W-1:0]         r_b, n_b;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic                    r_pend, n_pend;
    t_result                 r_res, n_res;

    logic                    w_we;
    logic [NODE_W-1:0]       w_waddr;
    logic signed [SUM_W-1:0] w_wdata;
    logic                    w_re;
    logic [NODE_W-1:0]       w_raddr;
    logic [NODE_W-1:0]       w_leaf;
    logic [NODE_W-1:0]       w_parent;
    logic signed [SUM_W-1:0] w_sum;
    logic [AB_W-1:0]         w_bm1;

    assign w_leaf   = NODE_W'(LEAVES) + NODE_W'(i_cmd.leaf);
    assign w_parent = r_node >> 1;
    assign w_sum    = r_cur + r_rdata;
    assign w_bm1    = r_b - AB_W'(1);

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_node    = r_node;
        n_cur     = r_cur;
        n_a       = r_a;
        n_b       = r_b;
        // fold in the node read issued last cycle
        n_acc     = r_pend ? (r_acc + r_rdata) : r_acc;
        n_pend    = 1'b0;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_clr_idx;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr   = r_node ^ NODE_W'(1);
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                n_clr_idx = r_clr_idx + NODE_W'(1);
                if (r_clr_idx == NODE_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_WRITE: begin
                            // store the leaf and fetch its sibling together
                            w_we    = 1'b1;
                            w_waddr = w_leaf;
                            w_wdata = SUM_W'(i_cmd.value);
                            n_cur   = SUM_W'(i_cmd.value);
                            n_node  = w_leaf;
                            w_re    = 1'b1;
                            w_raddr = w_leaf ^ NODE_W'(1);
                            n_state = S_WSUM;
                        end
                        CMD_QUERY: begin
                            n_a     = AB_W'(LEAVES) + AB_W'(i_cmd.lo);
                            n_b     = AB_W'(LEAVES) + AB_W'(i_cmd.hi) + AB_W'(1);
                            n_acc   = '0;
                            n_state = S_QA;
                        end
                        default: begin
                            n_res.range_total = '0;
                            n_res.status      = i_cmd.status;
                            n_state           = S_REPLY;
                        end
                    endcase
                end
            end
            S_WSUM: begin
                w_we    = 1'b1;
                w_waddr = w_parent;
                w_wdata = w_sum;
                n_cur   = w_sum;
                n_node  = w_parent;
                if (w_parent == NODE_W'(1)) begin
                    n_res.range_total = '0;
                    n_res.status      = 1'b0;
                    n_state           = S_REPLY;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_parent ^ NODE_W'(1);
                end
            end
            S_QA: begin
                if (r_a < r_b) begin
                    w_re    = r_a[0];
                    w_raddr = r_a[NODE_W-1:0];
                    n_pend  = r_a[0];
                    n_state = S_QB;
                end else begin
                    n_res.range_total = n_acc;
                    n_res.status      = 1'b0;
                    n_state           = S_REPLY;
                end
            end
            S_QB: begin
                w_re    = r_b[0];
                w_raddr = w_bm1[NODE_W-1:0];
                n_pend  = r_b[0];
                // climb one level on both bounds
                n_a     = (r_a + AB_W'(r_a[0])) >> 1;
                n_b     = r_b >> 1;
                n_state = S_QA;
            end
            S_REPLY: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_pend    <= n_pend;
        end
        r_node <= n_node;
        r_cur  <= n_cur;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    assign o_res      = r_res;
    assign o_clearing = (r_state == S_CLEAR);

endmodule

// ===== hw/rtl/rsst_outq.sv =====
// Two-entry result queue that drives the result side
module rsst_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsst_pkg::t_result i_data,
    input  logic              i_push,
    output logic              o_full,
    output rsst_pkg::t_result o_data,
    output logic              o_empty,
    input  logic              i_pop
);
    import rsst_pkg::*;

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/range_sum_segment_tree_top.sv =====
// Top level of the range-sum segment tree
// Sum tree over 1024 signed 32-bit leaves with point writes and inclusive range
// queries, both sides seen as queues. After reset the tree memory is swept to
// zero with full held high. A write item stores its leaf, then writes the sum
// of each node and its sibling into the parent on the way to the root, then
// posts the result. A query climbs one tree level per pass through the QA and
// QB states, one for each bound, and an inverted or empty range goes straight
// to its result. The tree memory gives one read and one write per cycle. The
// front queue takes up to two items ahead of the engine and the result queue
// holds two results.
`include "assert_macros.svh"

module range_sum_segment_tree_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsst_pkg::t_item   i_item,
    input  logic              push,
    output logic              full,
    output rsst_pkg::t_result o_result,
    output logic              empty,
    input  logic              pop
);
    import rsst_pkg::*;

    t_cmd    w_cmd;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    t_result w_res;
    logic    w_res_push;
    logic    w_res_full;
    logic    w_clearing;

    rsst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_push      (push),
        .i_hold      (w_clearing),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty),
        .i_cmd_pop   (w_cmd_pop)
    );

    rsst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full),
        .o_clearing  (w_clearing)
    );

    rsst_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_res),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .o_data  (o_result),
        .o_empty (empty),
        .i_pop   (pop)
    );

    `ASSERT_CLK(a_clear_blocks_input, w_clearing |-> full, "item accepted during clearing pass")
    `ASSERT_NEVER(a_res_overflow, w_res_push && w_res_full, "result pushed into full queue")
    `ASSERT_NEVER(a_cmd_underflow, w_cmd_pop && w_cmd_empty, "command popped from empty queue")
    `ASSERT_NEVER(a_err_total, !empty && o_result.status && |o_result.range_total, "err total")

endmodule

// ===== tb/sv/range_sum_segment_tree_checker.sv =====
// Transaction checker and tree predictor for the range-sum segment tree
`timescale 1ns / 1ps

package rsst_tb_pkg;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RANGE = 1'b1;

endpackage

module range_sum_segment_tree_checker
    import rsst_pkg::*;
    import rsst_tb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_push,
    input  logic    i_full,
    input  t_result i_result,
    input  logic    i_empty,
    input  logic    i_pop,
    output int      o_errors,
    output int      o_pending
);

    // node 1 is the root, leaf i sits at node LEAVES+i, node 0 unused
    logic signed [SUM_W-1:0] tree_node [0:NODES-1];
    t_result                 expected_results [$];

    function automatic t_result predict_result(input t_item it);
        t_result                 res;
        int unsigned             node;
        int unsigned             a;
        int unsigned             b;
        int unsigned             lo;
        int unsigned             hi;
        logic signed [SUM_W-1:0] acc;
        res = '0;
        acc = '0;
        if (it.mode == MODE_WRITE) begin
            if (it.position < LEAVES) begin
                node = LEAVES + it.position;
                tree_node[node] = {{(SUM_W-VAL_W){it.new_value[VAL_W-1]}}, it.new_value};
                node = node >> 1;
                while (node >= 1) begin
                    tree_node[node] = tree_node[2*node] + tree_node[2*node+1];
                    node = node >> 1;
                end
            end
            res.status = STATUS_OK;
        end else if (it.range_low > it.range_high) begin
            res.status = STATUS_BAD_RANGE;
        end else begin
            lo = it.range_low;
            hi = it.range_high;
            if (hi >= LEAVES)
                hi = LEAVES - 1;
            if (lo <= hi) begin
                a = lo + LEAVES;
                b = hi + LEAVES + 1;
                while (a < b) begin
                    if (a[0]) begin
                        acc = acc + tree_node[a];
                        a = a + 1;
                    end
                    if (b[0]) begin
                        b = b - 1;
                        acc = acc + tree_node[b];
                    end
                    a = a >> 1;
                    b = b >> 1;
                end
            end
            res.range_total = acc;
            res.status      = STATUS_OK;
        end
        return res;
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int n = 0; n < NODES; n++)
                tree_node[n] = '0;
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no transaction waiting, actual total %0d status %0b",
                             $time, $signed(i_result.range_total), i_result.status);
                    errs = errs + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.range_total !== i_result.range_total) begin
                        $display("%0t: range_total mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.range_total),
                                 $signed(i_result.range_total));
                        errs = errs + 1;
                    end
                    if (want.status !== i_result.status) begin
                        $display("%0t: status mismatch, expected %0b, actual %0b",
                                 $time, want.status, i_result.status);
                        errs = errs + 1;
                    end
                end
            end
            if (i_push && !i_full)
                expected_results.push_back(predict_result(i_item));
        end
        o_errors  <= o_errors + errs;
        o_pending <= expected_results.size();
    end

endmodule

// ===== tb/sv/range_sum_segment_tree_top_test.sv =====
// Stimulus, handshake pacing and verdict for the range-sum segment tree
`timescale 1ns / 1ps

module range_sum_segment_tree_top_test;

    import rsst_pkg::*;
    import rsst_tb_pkg::*;

    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 450;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    t_item   i_item  = '0;
    logic    push    = 1'b0;
    logic    full;
    t_result o_result;
    logic    empty;
    logic    pop     = 1'b0;

    int      fail_count;
    int      pending_count;
    int      idle_cycles = 0;
    int      burst_left  = 1;
    logic [15:0] pop_mask  = 16'hFFFF;
    int      pop_phase   = 0;

    range_sum_segment_tree_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .push     (push),
        .full     (full),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop)
    );

    range_sum_segment_tree_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_push    (push),
        .i_full    (full),
        .i_result  (o_result),
        .i_empty   (empty),
        .i_pop     (pop),
        .o_errors  (fail_count),
        .o_pending (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_item make_write(input logic [POS_W-1:0] pos,
                                         input logic signed [VAL_W-1:0] val);
        t_item it;
        it            = '0;
        it.mode       = MODE_WRITE;
        it.position   = pos;
        it.new_value  = val;
        // query fields carry noise, the block must ignore them
        it.range_low  = POS_W'($urandom);
        it.range_high = POS_W'($urandom);
        return it;
    endfunction

    function automatic t_item make_query(input logic [POS_W-1:0] lo,
                                         input logic [POS_W-1:0] hi);
        t_item it;
        it            = '0;
        it.mode       = MODE_QUERY;
        it.position   = POS_W'($urandom);
        it.new_value  = $urandom;
        it.range_low  = lo;
        it.range_high = hi;
        return it;
    endfunction

    // hold push until the transaction goes through, then pace the next burst
    task automatic send_item(input t_item it);
        int gap;
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // receiver stall pattern, reshuffled each time pop_phase wraps
    always @(posedge i_clk) begin
        if (pop_phase == 63) begin
            if ($urandom_range(0, 3) == 0)
                pop_mask <= 16'hFFFF;
            else
                pop_mask <= 16'($urandom) | (16'h1 << $urandom_range(0, 15));
        end
        pop_phase <= (pop_phase + 1) % 64;
        pop       <= i_rst_n && pop_mask[pop_phase % 16];
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int win_base;
        int win_span;
        int pick;
        int lo;
        int hi;
        logic signed [VAL_W-1:0] val;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of leaf values and positions
        send_item(make_write(10'd0,    32'sh7FFF_FFFF));
        send_item(make_write(10'd1023, 32'sh8000_0000));
        send_item(make_write(10'd511,  -32'sd1));
        send_item(make_write(10'd512,  32'sd1));
        send_item(make_write(10'd2,    32'sh5555_5555));
        send_item(make_write(10'd3,    32'shAAAA_AAAA));
        // queries over the whole tree, single leaves and a split across the root
        send_item(make_query(10'd0,    10'd1023));
        send_item(make_query(10'd0,    10'd0));
        send_item(make_query(10'd1023, 10'd1023));
        send_item(make_query(10'd511,  10'd512));
        send_item(make_query(10'd0,    10'd3));
        send_item(make_query(10'd1,    10'd1022));
        send_item(make_query(10'd100,  10'd200));
        // inverted ranges
        send_item(make_query(10'd5,    10'd4));
        send_item(make_query(10'd1023, 10'd0));
        // overwrite a leaf and look again
        send_item(make_write(10'd0,    32'sd0));
        send_item(make_query(10'd0,    10'd1));
        send_item(make_write(10'd1023, 32'sh7FFF_FFFF));
        send_item(make_query(10'd0,    10'd1023));

        win_base = 0;
        win_span = 1024;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // move the working window so queries land on written leaves
            if (k % 50 == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    win_base = 0;
                    win_span = 1024;
                end else begin
                    win_span = $urandom_range(1, 32);
                    win_base = $urandom_range(0, 1024 - win_span);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 4))
                    0: val = 32'sh7FFF_FFFF;
                    1: val = 32'sh8000_0000;
                    2: val = $signed(32'($urandom_range(0, 6))) - 32'sd3;
                    default: val = $urandom;
                endcase
                send_item(make_write(POS_W'(win_base + $urandom_range(0, win_span - 1)), val));
            end else if (pick < 55) begin
                lo = $urandom_range(1, 1023);
                hi = $urandom_range(0, lo - 1);
                send_item(make_query(POS_W'(lo), POS_W'(hi)));
            end else if (pick < 60) begin
                send_item(make_query(10'd0, 10'd1023));
            end else begin
                lo = win_base + $urandom_range(0, win_span - 1);
                hi = win_base + $urandom_range(0, win_span - 1);
                if (lo > hi)
                    send_item(make_query(POS_W'(hi), POS_W'(lo)));
                else
                    send_item(make_query(POS_W'(lo), POS_W'(hi)));
            end
        end
        push <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
